FILE: hdl/icrr_pkg.sv
// icrr_pkg: shared types and default sizes for the input change record/replay block
// used by the interfaces, the channel and pulse memories and the top level

package icrr_pkg;

  // default sizing, handed to the top level parameters
  localparam int PORT_COUNT_DEF         = 2;
  localparam int DEVICE_COUNT_DEF       = 4;
  localparam int INPUT_COUNT_DEF        = 16;
  localparam int PULSES_PER_CHANNEL_DEF = 256;

  // fixed field widths
  localparam int FuncW  = 3;
  localparam int TickW  = 16;
  localparam int ValueW = 16;
  localparam int TimeW  = 64;
  localparam int TotalW = 16;

  // operation codes of an input transaction
  typedef enum logic [FuncW-1:0] {
    FN_TICK    = 3'd0,
    FN_TRESET  = 3'd1,
    FN_TOG_REC = 3'd2,
    FN_TOG_MAC = 3'd3,
    FN_REPLAY  = 3'd4,
    FN_MREPLAY = 3'd5,
    FN_SAMPLE  = 3'd6,
    FN_QUERY   = 3'd7
  } func_e;

  // run mode, also reported on the result
  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_FULL  = 2'd1,
    MODE_MACRO = 2'd2,
    MODE_REC   = 2'd3
  } mode_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CHAN  = 2'd1,
    S_PULSE = 2'd2
  } state_e;

  // channel memory control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
    logic clr_pos;
  } chan_ctl_t;

  // pulse store control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } pulse_ctl_t;

endpackage

FILE: hdl/icrr_in_if.sv
// icrr_in_if: valid/ready channel carrying one input transaction
// depends on icrr_pkg for field widths

interface icrr_in_if;
  logic                               valid;
  logic                               ready;
  logic [icrr_pkg::FuncW-1:0]         func;
  logic [icrr_pkg::TickW-1:0]         tick_clocks;
  logic                               port_num;
  logic [1:0]                         device_num;
  logic [3:0]                         input_num;
  logic signed [icrr_pkg::ValueW-1:0] sample_value;

  modport source (
    output valid, func, tick_clocks, port_num, device_num, input_num, sample_value,
    input  ready
  );

  modport sink (
    input  valid, func, tick_clocks, port_num, device_num, input_num, sample_value,
    output ready
  );
endinterface

FILE: hdl/icrr_out_if.sv
// icrr_out_if: valid/ready channel carrying one result transaction
// depends on icrr_pkg for field widths

interface icrr_out_if;
  logic                               valid;
  logic                               ready;
  logic                               has_value;
  logic signed [icrr_pkg::ValueW-1:0] replay_value;
  logic [1:0]                         mode_now;
  logic [icrr_pkg::TotalW-1:0]        recorded_count;
  logic [icrr_pkg::TotalW-1:0]        replayed_count;
  logic                               store_overflow;

  modport source (
    output valid, has_value, replay_value, mode_now, recorded_count, replayed_count,
           store_overflow,
    input  ready
  );

  modport sink (
    input  valid, has_value, replay_value, mode_now, recorded_count, replayed_count,
           store_overflow,
    output ready
  );
endinterface

FILE: hdl/icrr_chan_mem.sv
// icrr_chan_mem: per-channel state memory (pulse count, replay position,
// held value, last stored value) with valid bits; depends on icrr_pkg

module icrr_chan_mem #(
  parameter int CHANNELS = 128,
  parameter int CH_W     = 7,
  parameter int CNT_W    = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  icrr_pkg::chan_ctl_t           ctl_i,
  input  logic [CH_W-1:0]               raddr_i,
  input  logic [CH_W-1:0]               waddr_i,
  input  logic [CNT_W-1:0]              wcnt_i,
  input  logic [CNT_W-1:0]              wpos_i,
  input  logic [icrr_pkg::ValueW-1:0]   wheld_i,
  input  logic [icrr_pkg::ValueW-1:0]   wlast_i,
  output logic [CNT_W-1:0]              rcnt_o,
  output logic [CNT_W-1:0]              rpos_o,
  output logic [icrr_pkg::ValueW-1:0]   rheld_o,
  output logic [icrr_pkg::ValueW-1:0]   rlast_o
);

  localparam int VW   = icrr_pkg::ValueW;
  localparam int EntW = 2 * CNT_W + 2 * VW;

  logic [EntW-1:0]     mem_q [CHANNELS];
  logic [EntW-1:0]     rdata_q;
  logic [CHANNELS-1:0] rec_vld_q;
  logic [CHANNELS-1:0] pos_vld_q;
  logic                rec_vld_rd_q;
  logic                pos_vld_rd_q;

  // storage array, one read and one write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= {wcnt_i, wpos_i, wheld_i, wlast_i};
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // valid bits: recording start clears all, replay start clears positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_vld_q    <= '0;
      pos_vld_q    <= '0;
      rec_vld_rd_q <= 1'b0;
      pos_vld_rd_q <= 1'b0;
    end else begin
      if (ctl_i.clr_all) begin
        rec_vld_q <= '0;
        pos_vld_q <= '0;
      end else if (ctl_i.clr_pos) begin
        pos_vld_q <= '0;
      end
      if (ctl_i.wr_en) begin
        rec_vld_q[waddr_i] <= 1'b1;
        pos_vld_q[waddr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rec_vld_rd_q <= rec_vld_q[raddr_i];
        pos_vld_rd_q <= pos_vld_q[raddr_i];
      end
    end
  end

  // an entry that is not valid reads as zero
  assign rcnt_o  = rec_vld_rd_q ? rdata_q[EntW-1 -: CNT_W]          : '0;
  assign rpos_o  = pos_vld_rd_q ? rdata_q[EntW-CNT_W-1 -: CNT_W]    : '0;
  assign rheld_o = rec_vld_rd_q ? rdata_q[2*VW-1 -: VW]             : '0;
  assign rlast_o = rec_vld_rd_q ? rdata_q[VW-1:0]                   : '0;

endmodule

FILE: hdl/icrr_pulse_mem.sv
// icrr_pulse_mem: pulse store holding timestamp and value of every recorded change
// single port, registered read; depends on icrr_pkg

module icrr_pulse_mem #(
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = 15
) (
  input  logic                        clk_i,
  input  icrr_pkg::pulse_ctl_t        ctl_i,
  input  logic [ADDR_W-1:0]           addr_i,
  input  logic [icrr_pkg::TimeW-1:0]  wtime_i,
  input  logic [icrr_pkg::ValueW-1:0] wval_i,
  output logic [icrr_pkg::TimeW-1:0]  rtime_o,
  output logic [icrr_pkg::ValueW-1:0] rval_o
);

  logic [icrr_pkg::TimeW-1:0]  time_mem_q [DEPTH];
  logic [icrr_pkg::ValueW-1:0] val_mem_q  [DEPTH];

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      time_mem_q[addr_i] <= wtime_i;
      val_mem_q[addr_i]  <= wval_i;
    end
    if (ctl_i.rd_en) begin
      rtime_o <= time_mem_q[addr_i];
      rval_o  <= val_mem_q[addr_i];
    end
  end

endmodule

FILE: hdl/input_change_record_replay.sv
// input_change_record_replay: top level, sequencer, time and mode registers
// depends on icrr_pkg, icrr_in_if, icrr_out_if, icrr_chan_mem, icrr_pulse_mem

// Records controller input changes per channel with timestamps and replays them.
// Each input transaction is taken one at a time: the channel memory is read in
// the accept cycle and most transactions commit from the channel stage; a replay
// query that reaches a pending pulse commits from the pulse stage instead, after
// the registered read of the pulse store. A commit waits while the
// output register still holds an untaken result, but the next transaction is
// accepted as soon as the previous one has committed. Channel state resets
// through per-channel valid bits, so there is no clearing pass after reset or on
// recording and replay start; the pulse store holds garbage until written.

module input_change_record_replay #(
  parameter int PORT_COUNT         = icrr_pkg::PORT_COUNT_DEF,
  parameter int DEVICE_COUNT       = icrr_pkg::DEVICE_COUNT_DEF,
  parameter int INPUT_COUNT        = icrr_pkg::INPUT_COUNT_DEF,
  parameter int PULSES_PER_CHANNEL = icrr_pkg::PULSES_PER_CHANNEL_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  icrr_in_if.sink           in_i,
  icrr_out_if.source        out_o
);

  localparam int Channels = PORT_COUNT * DEVICE_COUNT * INPUT_COUNT;
  localparam int ChW      = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int CntW     = $clog2(PULSES_PER_CHANNEL + 1);
  localparam int Depth    = Channels * PULSES_PER_CHANNEL;
  localparam int PaW      = $clog2(Depth);
  localparam int VW       = icrr_pkg::ValueW;
  localparam int TW       = icrr_pkg::TimeW;
  localparam int NW       = icrr_pkg::TotalW;

  icrr_pkg::state_e state_q, state_d;
  icrr_pkg::mode_e  mode_q, mode_d;
  logic [TW-1:0]    time_q, time_d;
  logic [TW-1:0]    rec_base_q, rec_base_d;
  logic [TW-1:0]    rep_base_q, rep_base_d;
  logic [TW-1:0]    elapsed_q;
  logic [NW-1:0]    recorded_q, recorded_d;
  logic [NW-1:0]    replayed_q, replayed_d;

  // latched transaction
  icrr_pkg::func_e            func_q;
  logic [icrr_pkg::TickW-1:0] tick_q;
  logic [VW-1:0]              sval_q;
  logic [ChW-1:0]             ch_q;
  logic                       in_range_q;

  logic           in_fire;
  logic           in_range_in;
  logic [ChW-1:0] ch_in;
  logic           out_free;
  logic           fin;
  logic           need_pulse;
  logic           rep_mode;

  icrr_pkg::chan_ctl_t  chan_ctl;
  icrr_pkg::pulse_ctl_t pulse_ctl;
  logic [CntW-1:0] c_cnt, c_pos, cw_cnt, cw_pos;
  logic [VW-1:0]   c_held, c_last, cw_held, cw_last;
  logic [TW-1:0]   p_time, pw_time;
  logic [VW-1:0]   p_val;
  logic [CntW-1:0] pidx;
  logic [PaW-1:0]  paddr;

  logic            res_has, res_ovf;
  logic [VW-1:0]   res_rval;
  logic            out_valid_q, out_valid_d;
  logic            out_has_q, out_ovf_q;
  logic [VW-1:0]   out_rval_q;
  logic [1:0]      out_mode_q;
  logic [NW-1:0]   out_rec_q, out_rep_q;

  // channel selection from the input payload
  always_comb begin
    in_range_in = (int'(in_i.port_num) < PORT_COUNT) &&
                  (int'(in_i.device_num) < DEVICE_COUNT) &&
                  (int'(in_i.input_num) < INPUT_COUNT);
    ch_in = '0;
    if (in_range_in) begin
      ch_in = ChW'((int'(in_i.port_num) * DEVICE_COUNT + int'(in_i.device_num)) *
                   INPUT_COUNT + int'(in_i.input_num));
    end
  end

  assign in_i.ready = (state_q == icrr_pkg::S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign rep_mode   = (mode_q == icrr_pkg::MODE_FULL) || (mode_q == icrr_pkg::MODE_MACRO);

  // query that must look at the channel's next pulse
  assign need_pulse = (state_q == icrr_pkg::S_CHAN) && (func_q == icrr_pkg::FN_QUERY) &&
                      rep_mode && (replayed_q != recorded_q) && in_range_q &&
                      (c_pos < c_cnt);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      icrr_pkg::S_IDLE: begin
        if (in_fire) state_d = icrr_pkg::S_CHAN;
      end
      icrr_pkg::S_CHAN: begin
        if (need_pulse) state_d = icrr_pkg::S_PULSE;
        else if (out_free) state_d = icrr_pkg::S_IDLE;
      end
      icrr_pkg::S_PULSE: begin
        if (out_free) state_d = icrr_pkg::S_IDLE;
      end
      default: state_d = icrr_pkg::S_IDLE;
    endcase
  end

  // pulse store address: channel base plus pulse index
  assign pidx  = (state_q == icrr_pkg::S_CHAN && func_q == icrr_pkg::FN_SAMPLE) ? c_cnt : c_pos;
  assign paddr = PaW'(ch_q) * PaW'(PULSES_PER_CHANNEL) + PaW'(pidx);

  // datapath and memory control
  always_comb begin
    mode_d     = mode_q;
    time_d     = time_q;
    rec_base_d = rec_base_q;
    rep_base_d = rep_base_q;
    recorded_d = recorded_q;
    replayed_d = replayed_q;
    chan_ctl   = '0;
    pulse_ctl  = '0;
    cw_cnt     = c_cnt;
    cw_pos     = c_pos;
    cw_held    = c_held;
    cw_last    = c_last;
    pw_time    = time_q - rec_base_q;
    res_has    = 1'b0;
    res_rval   = '0;
    res_ovf    = 1'b0;
    fin        = 1'b0;
    case (state_q)
      icrr_pkg::S_IDLE: begin
        chan_ctl.rd_en = in_fire;
      end
      icrr_pkg::S_CHAN: begin
        if (need_pulse) begin
          pulse_ctl.rd_en = 1'b1;
        end else if (out_free) begin
          fin = 1'b1;
          case (func_q)
            icrr_pkg::FN_TICK: begin
              time_d = time_q + TW'(tick_q);
            end
            icrr_pkg::FN_TRESET: begin
              time_d = '0;
              mode_d = icrr_pkg::MODE_OFF;
            end
            icrr_pkg::FN_TOG_REC, icrr_pkg::FN_TOG_MAC: begin
              if (mode_q == icrr_pkg::MODE_REC) begin
                mode_d = icrr_pkg::MODE_OFF;
              end else begin
                chan_ctl.clr_all = 1'b1;
                recorded_d = '0;
                replayed_d = '0;
                rec_base_d = (func_q == icrr_pkg::FN_TOG_MAC) ? time_q : '0;
                rep_base_d = '0;
                mode_d     = icrr_pkg::MODE_REC;
              end
            end
            icrr_pkg::FN_REPLAY: begin
              chan_ctl.clr_pos = 1'b1;
              rep_base_d = '0;
              replayed_d = '0;
              mode_d     = icrr_pkg::MODE_FULL;
            end
            icrr_pkg::FN_MREPLAY: begin
              chan_ctl.clr_pos = 1'b1;
              rep_base_d = time_q;
              replayed_d = '0;
              mode_d     = icrr_pkg::MODE_MACRO;
            end
            icrr_pkg::FN_SAMPLE: begin
              // store only a change; a full channel drops it
              if (mode_q == icrr_pkg::MODE_REC && in_range_q &&
                  !(c_cnt != '0 && c_last == sval_q)) begin
                if (c_cnt >= CntW'(PULSES_PER_CHANNEL)) begin
                  res_ovf = 1'b1;
                end else begin
                  pulse_ctl.wr_en = 1'b1;
                  chan_ctl.wr_en  = 1'b1;
                  cw_cnt     = c_cnt + CntW'(1);
                  cw_last    = sval_q;
                  recorded_d = recorded_q + NW'(1);
                end
              end
            end
            icrr_pkg::FN_QUERY: begin
              // all pulses replayed ends the replay
              if (rep_mode && replayed_q == recorded_q) begin
                mode_d = icrr_pkg::MODE_OFF;
              end
            end
            default: begin
            end
          endcase
        end
      end
      icrr_pkg::S_PULSE: begin
        if (out_free) begin
          fin      = 1'b1;
          res_has  = 1'b1;
          res_rval = c_held;
          if (elapsed_q >= p_time) begin
            chan_ctl.wr_en = 1'b1;
            cw_pos     = c_pos + CntW'(1);
            cw_held    = p_val;
            replayed_d = replayed_q + NW'(1);
            res_rval   = p_val;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register handoff
  always_comb begin
    out_valid_d = out_valid_q;
    if (fin) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= icrr_pkg::S_IDLE;
      mode_q      <= icrr_pkg::MODE_OFF;
      time_q      <= '0;
      rec_base_q  <= '0;
      rep_base_q  <= '0;
      recorded_q  <= '0;
      replayed_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      time_q      <= time_d;
      rec_base_q  <= rec_base_d;
      rep_base_q  <= rep_base_d;
      recorded_q  <= recorded_d;
      replayed_q  <= replayed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q     <= icrr_pkg::func_e'(in_i.func);
      tick_q     <= in_i.tick_clocks;
      sval_q     <= in_i.sample_value;
      ch_q       <= ch_in;
      in_range_q <= in_range_in;
    end
    if (pulse_ctl.rd_en) begin
      elapsed_q <= time_q - rep_base_q;
    end
    if (fin) begin
      out_has_q  <= res_has;
      out_rval_q <= res_rval;
      out_ovf_q  <= res_ovf;
      out_mode_q <= mode_d;
      out_rec_q  <= recorded_d;
      out_rep_q  <= replayed_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.has_value      = out_has_q;
  assign out_o.replay_value   = $signed(out_rval_q);
  assign out_o.mode_now       = out_mode_q;
  assign out_o.recorded_count = out_rec_q;
  assign out_o.replayed_count = out_rep_q;
  assign out_o.store_overflow = out_ovf_q;

  // per-channel state
  icrr_chan_mem #(
    .CHANNELS (Channels),
    .CH_W     (ChW),
    .CNT_W    (CntW)
  ) u_chan_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (chan_ctl),
    .raddr_i (ch_in),
    .waddr_i (ch_q),
    .wcnt_i  (cw_cnt),
    .wpos_i  (cw_pos),
    .wheld_i (cw_held),
    .wlast_i (cw_last),
    .rcnt_o  (c_cnt),
    .rpos_o  (c_pos),
    .rheld_o (c_held),
    .rlast_o (c_last)
  );

  // pulse timestamps and values
  icrr_pulse_mem #(
    .DEPTH  (Depth),
    .ADDR_W (PaW)
  ) u_pulse_mem (
    .clk_i   (clk_i),
    .ctl_i   (pulse_ctl),
    .addr_i  (paddr),
    .wtime_i (pw_time),
    .wval_i  (sval_q),
    .rtime_o (p_time),
    .rval_o  (p_val)
  );

`ifndef ASSERT_OFF
  // an accepted transaction always moves to the channel stage in the next cycle
  a_accept_to_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == icrr_pkg::S_CHAN)
    else $error("accepted transaction did not move to channel stage");

  // pulse store is written only by a sample while recording
  a_pulse_wr_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_ctl.wr_en |-> (mode_q == icrr_pkg::MODE_REC && func_q == icrr_pkg::FN_SAMPLE))
    else $error("pulse store written outside a recorded sample");

  // channel memory never reads and writes in the same cycle
  a_chan_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(chan_ctl.rd_en && chan_ctl.wr_en))
    else $error("channel memory read and write overlap");

  // pulse stage follows only a channel stage
  a_pulse_after_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == icrr_pkg::S_PULSE && $past(state_q) != icrr_pkg::S_PULSE) |->
    $past(state_q) == icrr_pkg::S_CHAN)
    else $error("pulse stage entered without channel read");

  // a commit never overwrites an untaken result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && out_valid_q) |-> out_o.ready)
    else $error("result overwritten before it was taken");
`endif

endmodule
